@@ sv/ffha_pkg.sv @@
// Shared types, codes and sizes for the first-fit hole allocator.
// Depends on nothing; every other file of the block imports it.
package ffha_pkg;

	localparam int NUM_HOLES = 64;
	localparam int IDX_W     = $clog2(NUM_HOLES);
	localparam int CNT_W     = $clog2(NUM_HOLES + 1);

	// Descriptor kinds; the fourth code reads as spare.
	localparam logic [1:0] KIND_SPARE = 2'd0;
	localparam logic [1:0] KIND_FREE  = 2'd1;
	localparam logic [1:0] KIND_USED  = 2'd2;

	// Request operations.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_SPACE = 3'd1;
	localparam logic [2:0] ST_NO_DESC  = 3'd2;
	localparam logic [2:0] ST_INVALID  = 3'd3;
	localparam logic [2:0] ST_OVERLAP  = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_HEAP_BASE = 2'd0;
	localparam logic [1:0] CFG_HEAP_SIZE = 2'd1;
	localparam logic [1:0] CFG_MIN_SPLIT = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [31:0] request_size;
		logic [31:0] block_address;
	} in_item_t;

	typedef struct packed {
		logic [31:0] granted_address;
		logic [2:0]  status;
	} out_item_t;

	// One descriptor word as held in the table memory.
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
	} hole_t;

endpackage

@@ sv/ffha_mem.sv @@
// Descriptor table memory: start and length of every hole.
// One write port, one read port with registered data. Uses ffha_pkg.
module ffha_mem (
	input  logic                            clk,
	input  logic                            wr_en,
	input  logic [ffha_pkg::IDX_W-1:0]      wr_addr,
	input  ffha_pkg::hole_t                 wr_data,
	input  logic [ffha_pkg::IDX_W-1:0]      rd_addr,
	output ffha_pkg::hole_t                 rd_data
);
	import ffha_pkg::*;

	hole_t mem_q [NUM_HOLES];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ sv/first_fit_hole_allocator.sv @@
// First-fit hole allocator: top level with sequencer, kind flags and result register.
// Depends on ffha_pkg and ffha_mem.
//
// Each request (allocate or free) scans the whole descriptor table once through the
// single read port of the table memory, one entry per cycle, while one compare unit
// keeps the first fit, the lowest spare, the used block and its free neighbors. The
// scan is followed by the decision step and the result when nothing is written back
// (no space, no descriptor, whole-hole allocate, invalid pointer, overlap); a split
// or a successful free adds the write-back states, and the first allocate adds a
// set-up state that writes the initial hole. A free of address zero skips the scan
// and goes straight to the result. A stalled output holds the result back. The input
// is stalled until the result is loaded into the output register, so one request is
// in flight at a time. The user must write configuration through the plain write port
// only while idle (the block does not enforce it); base and size take effect at the
// first allocate after reset, the split threshold at the next allocate.
module first_fit_hole_allocator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ffha_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ffha_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import ffha_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_INIT   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_WR1    = 3'd4;
	localparam logic [2:0] S_WR2    = 3'd5;
	localparam logic [2:0] S_RESP   = 3'd6;

	logic [2:0]       state_q;
	logic [31:0]      heap_base_q, heap_size_q, min_split_q;
	logic             pool_ready_q;
	logic [1:0]       kind_q [NUM_HOLES];

	logic             op_q;
	logic [31:0]      want_q, addr_q;
	logic [CNT_W-1:0] scan_cnt_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             fit_found_q, sp_found_q, blk_found_q, nxt_found_q, prv_found_q;
	logic [IDX_W-1:0] fit_idx_q, sp_idx_q, blk_idx_q, nxt_idx_q, prv_idx_q;
	logic [31:0]      fit_start_q, fit_len_q, blk_len_q;
	logic [31:0]      nxt_start_q, nxt_len_q, prv_start_q, prv_len_q;

	logic             join_prev_q, blk_len_ok_q;
	logic [31:0]      new_len_q;
	logic             wr1_en_q, wr2_en_q;
	logic [IDX_W-1:0] wr1_idx_q, wr2_idx_q;
	hole_t            wr1_data_q, wr2_data_q;

	logic [31:0]      res_addr_q;
	logic [2:0]       res_status_q;
	logic             out_valid_q;
	out_item_t        out_data_q;
	logic             load_res;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	hole_t            mem_wdata, rd_data;

	// Compare unit signals for the entry leaving the read port.
	logic [1:0]       cur_kind;
	logic             is_free, is_used;
	logic             fit_hit, sp_hit, blk_hit, nxt_hit, prv_hit;

	// Decision arithmetic.
	logic [31:0]      rem;
	logic [32:0]      blk_end, prv_end, nxt_end;
	logic [32:0]      merged_len;

	ffha_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (mem_raddr),
		.rd_data (rd_data)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The result register takes a new beat when it is empty or being drained.
	assign load_res = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	// Memory port selection: the scan reads, set-up and write-back states write.
	always_comb begin
		mem_raddr = scan_cnt_q[IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = wr1_idx_q;
		mem_wdata = wr1_data_q;
		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = '{start: heap_base_q, length: heap_size_q};
			end
			S_WR1: begin
				mem_we = wr1_en_q;
			end
			S_WR2: begin
				mem_we    = wr2_en_q;
				mem_waddr = wr2_idx_q;
				mem_wdata = wr2_data_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Per-entry tests during the scan.
	always_comb begin
		cur_kind = kind_q[idx_s1];
		is_free  = (cur_kind == KIND_FREE);
		is_used  = (cur_kind == KIND_USED);
		fit_hit  = is_free && (rd_data.length >= want_q) &&
			(!fit_found_q || (rd_data.start < fit_start_q));
		sp_hit   = !is_free && !is_used && !sp_found_q;
		blk_hit  = is_used && (rd_data.start == addr_q) && !blk_found_q;
		nxt_hit  = is_free && (rd_data.start > addr_q) &&
			(!nxt_found_q || (rd_data.start < nxt_start_q));
		prv_hit  = is_free && (rd_data.start <= addr_q) &&
			(!prv_found_q || (rd_data.start >= prv_start_q));
	end

	// Arithmetic for the decision step.
	always_comb begin
		rem        = fit_len_q - want_q;
		blk_end    = {1'b0, addr_q} + {1'b0, blk_len_q};
		prv_end    = {1'b0, prv_start_q} + {1'b0, prv_len_q};
		nxt_end    = {1'b0, nxt_start_q} + {1'b0, nxt_len_q};
		merged_len = nxt_end - {1'b0, addr_q};
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q <= 32'd4096;
			heap_size_q <= 32'd65536;
			min_split_q <= 32'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEAP_BASE: heap_base_q <= cfg_data;
				CFG_HEAP_SIZE: heap_size_q <= cfg_data;
				CFG_MIN_SPLIT: min_split_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer, kind flags and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pool_ready_q <= 1'b0;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int k = 0; k < NUM_HOLES; k++) begin
				kind_q[k] <= KIND_SPARE;
			end
		end else begin
			if (out_valid_q && !out_stall && !load_res) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q        <= in_data.operation;
						want_q      <= in_data.request_size;
						addr_q      <= in_data.block_address;
						scan_cnt_q  <= '0;
						valid_s1    <= 1'b0;
						fit_found_q <= 1'b0;
						sp_found_q  <= 1'b0;
						blk_found_q <= 1'b0;
						nxt_found_q <= 1'b0;
						prv_found_q <= 1'b0;
						wr1_en_q    <= 1'b0;
						wr2_en_q    <= 1'b0;
						res_addr_q  <= '0;
						res_status_q <= ST_OK;
						if (in_data.operation == OP_FREE && in_data.block_address == '0) begin
							state_q <= S_RESP;
						end else if (in_data.operation == OP_ALLOC && !pool_ready_q) begin
							state_q <= S_INIT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_INIT: begin
					// Nothing was allocated since reset, so every other entry is still spare.
					kind_q[0]    <= KIND_FREE;
					pool_ready_q <= 1'b1;
					state_q      <= S_SCAN;
				end
				S_SCAN: begin
					valid_s1 <= (scan_cnt_q < CNT_W'(NUM_HOLES));
					idx_s1   <= scan_cnt_q[IDX_W-1:0];
					if (scan_cnt_q < CNT_W'(NUM_HOLES)) begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end else begin
						state_q <= S_DECIDE;
					end
					if (valid_s1) begin
						if (fit_hit) begin
							fit_found_q <= 1'b1;
							fit_idx_q   <= idx_s1;
							fit_start_q <= rd_data.start;
							fit_len_q   <= rd_data.length;
						end
						if (sp_hit) begin
							sp_found_q <= 1'b1;
							sp_idx_q   <= idx_s1;
						end
						if (blk_hit) begin
							blk_found_q <= 1'b1;
							blk_idx_q   <= idx_s1;
							blk_len_q   <= rd_data.length;
						end
						if (nxt_hit) begin
							nxt_found_q <= 1'b1;
							nxt_idx_q   <= idx_s1;
							nxt_start_q <= rd_data.start;
							nxt_len_q   <= rd_data.length;
						end
						if (prv_hit) begin
							prv_found_q <= 1'b1;
							prv_idx_q   <= idx_s1;
							prv_start_q <= rd_data.start;
							prv_len_q   <= rd_data.length;
						end
					end
				end
				S_DECIDE: begin
					valid_s1 <= 1'b0;
					state_q  <= S_RESP;
					if (op_q == OP_ALLOC) begin
						if (!fit_found_q) begin
							res_status_q <= ST_NO_SPACE;
						end else if (rem > min_split_q) begin
							if (!sp_found_q) begin
								res_status_q <= ST_NO_DESC;
							end else begin
								// Split: front part becomes a used block in a spare slot.
								kind_q[sp_idx_q] <= KIND_USED;
								wr1_en_q   <= 1'b1;
								wr1_idx_q  <= sp_idx_q;
								wr1_data_q <= '{start: fit_start_q, length: want_q};
								wr2_en_q   <= 1'b1;
								wr2_idx_q  <= fit_idx_q;
								wr2_data_q <= '{start: fit_start_q + want_q, length: rem};
								res_addr_q <= fit_start_q;
								state_q    <= S_WR1;
							end
						end else begin
							kind_q[fit_idx_q] <= KIND_USED;
							res_addr_q        <= fit_start_q;
						end
					end else begin
						if (!blk_found_q) begin
							res_status_q <= ST_INVALID;
						end else if (nxt_found_q && (blk_end > {1'b0, nxt_start_q})) begin
							res_status_q <= ST_OVERLAP;
						end else begin
							// Free the block, then merge with the neighbors it touches.
							join_prev_q <= prv_found_q && (prv_end == {1'b0, addr_q});
							blk_len_ok_q <= 1'b1;
							if (nxt_found_q && (blk_end == {1'b0, nxt_start_q})) begin
								kind_q[nxt_idx_q] <= KIND_SPARE;
								new_len_q  <= merged_len[31:0];
								wr1_en_q   <= 1'b1;
								wr1_idx_q  <= blk_idx_q;
								wr1_data_q <= '{start: addr_q, length: merged_len[31:0]};
							end else begin
								new_len_q <= blk_len_q;
							end
							if (prv_found_q && (prv_end == {1'b0, addr_q})) begin
								kind_q[blk_idx_q] <= KIND_SPARE;
							end else begin
								kind_q[blk_idx_q] <= KIND_FREE;
							end
							state_q <= S_WR1;
						end
					end
				end
				S_WR1: begin
					if (op_q == OP_FREE && join_prev_q && blk_len_ok_q) begin
						wr2_en_q   <= 1'b1;
						wr2_idx_q  <= prv_idx_q;
						wr2_data_q <= '{start: prv_start_q,
							length: addr_q + new_len_q - prv_start_q};
					end
					state_q <= S_WR2;
				end
				S_WR2: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (load_res) begin
						out_valid_q <= 1'b1;
						out_data_q  <= '{granted_address: res_addr_q, status: res_status_q};
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The scan always ends in the decision step after the last entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && scan_cnt_q == CNT_W'(NUM_HOLES)) |=> (state_q == S_DECIDE))
		else $error("scan did not hand over to the decision step");

	// The table memory is written only by set-up and write-back.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_INIT || state_q == S_WR1 || state_q == S_WR2))
		else $error("table written outside set-up or write-back");

	// An accepted beat starts work at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != S_IDLE))
		else $error("accepted beat left the sequencer idle");

	// Once the pool is set up it stays set up until reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(pool_ready_q))
		else $error("pool set-up flag dropped");

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for first_fit_hole_allocator: directed and random allocate/free beats.
// Depends on ffha_pkg and the allocator RTL; holds its own table-based prediction of results.
`timescale 1ns / 1ps
module tb;
	import ffha_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	first_fit_hole_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Mirror of the descriptor table and configuration.
	logic [31:0] pred_start [NUM_HOLES];
	logic [31:0] pred_len [NUM_HOLES];
	logic [1:0] pred_kind [NUM_HOLES];
	logic pred_ready;
	logic [31:0] pred_base, pred_size, pred_split;

	in_item_t request_q[$];
	out_item_t grant_q[$];
	logic [31:0] live_blocks[$];
	int errors;
	int idle_cycles;
	int hold_cycles;
	int send_gap;
	int recv_gap;
	bit stop_recv;

	function automatic void reset_table();
		for (int k = 0; k < NUM_HOLES; k++) begin
			pred_kind[k] = KIND_SPARE;
			pred_start[k] = '0;
			pred_len[k] = '0;
		end
		pred_ready = 1'b0;
		pred_base = 32'd4096;
		pred_size = 32'd65536;
		pred_split = 32'd16;
	endfunction

	function automatic logic [32:0] hole_end(int k);
		return {1'b0, pred_start[k]} + {1'b0, pred_len[k]};
	endfunction

	// Predicts one allocate result and updates the mirrored table.
	function automatic out_item_t predict_alloc(logic [31:0] want);
		out_item_t r;
		int fit;
		int sp;
		r = '0;
		fit = -1;
		sp = -1;
		if (!pred_ready) begin
			for (int k = 0; k < NUM_HOLES; k++) pred_kind[k] = KIND_SPARE;
			pred_start[0] = pred_base;
			pred_len[0] = pred_size;
			pred_kind[0] = KIND_FREE;
			pred_ready = 1'b1;
		end
		for (int k = 0; k < NUM_HOLES; k++)
			if (pred_kind[k] == KIND_FREE && pred_len[k] >= want &&
					(fit < 0 || pred_start[k] < pred_start[fit]))
				fit = k;
		if (fit < 0) begin
			r.status = ST_NO_SPACE;
			return r;
		end
		if (pred_len[fit] - want > pred_split) begin
			for (int k = NUM_HOLES - 1; k >= 0; k--)
				if (pred_kind[k] != KIND_FREE && pred_kind[k] != KIND_USED) sp = k;
			if (sp < 0) begin
				r.status = ST_NO_DESC;
				return r;
			end
			pred_start[sp] = pred_start[fit];
			pred_len[sp] = want;
			pred_kind[sp] = KIND_USED;
			pred_start[fit] = pred_start[fit] + want;
			pred_len[fit] = pred_len[fit] - want;
			r.granted_address = pred_start[sp];
		end else begin
			pred_kind[fit] = KIND_USED;
			r.granted_address = pred_start[fit];
		end
		r.status = ST_OK;
		return r;
	endfunction

	// Predicts one free result, including overlap and coalescing.
	function automatic out_item_t predict_free(logic [31:0] addr);
		out_item_t r;
		int blk, nxt, prv;
		logic [32:0] blk_end;
		bit join_prev, join_next;
		r = '0;
		blk = -1;
		nxt = -1;
		prv = -1;
		r.status = ST_OK;
		if (addr == 0) return r;
		for (int k = NUM_HOLES - 1; k >= 0; k--)
			if (pred_kind[k] == KIND_USED && pred_start[k] == addr) blk = k;
		if (blk < 0) begin
			r.status = ST_INVALID;
			return r;
		end
		for (int k = 0; k < NUM_HOLES; k++) begin
			if (pred_kind[k] != KIND_FREE) continue;
			if (pred_start[k] > addr) begin
				if (nxt < 0 || pred_start[k] < pred_start[nxt]) nxt = k;
			end else if (prv < 0 || pred_start[k] >= pred_start[prv]) begin
				prv = k;
			end
		end
		blk_end = hole_end(blk);
		if (nxt >= 0 && blk_end > {1'b0, pred_start[nxt]}) begin
			r.status = ST_OVERLAP;
			return r;
		end
		pred_kind[blk] = KIND_FREE;
		join_prev = prv >= 0 && hole_end(prv) == {1'b0, addr};
		join_next = nxt >= 0 && blk_end == {1'b0, pred_start[nxt]};
		if (join_next) begin
			pred_len[blk] = 32'(hole_end(nxt) - {1'b0, addr});
			pred_kind[nxt] = KIND_SPARE;
		end
		if (join_prev) begin
			pred_len[prv] = 32'(hole_end(blk) - {1'b0, pred_start[prv]});
			pred_kind[blk] = KIND_SPARE;
		end
		return r;
	endfunction

	function automatic in_item_t make_req(logic op, logic [31:0] sz, logic [31:0] addr);
		in_item_t it;
		it.operation = op;
		it.request_size = sz;
		it.block_address = addr;
		return it;
	endfunction

	// Random request: mostly sensible allocates and frees of live blocks, some noise.
	function automatic in_item_t random_req();
		int pick;
		logic [31:0] a;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return make_req(OP_ALLOC, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3000),
				$urandom);
		if (pick < 85 && live_blocks.size() > 0) begin
			int i;
			i = $urandom_range(0, live_blocks.size() - 1);
			a = live_blocks[i];
			live_blocks.delete(i);
			return make_req(OP_FREE, $urandom, a);
		end
		if (pick < 92) return make_req(OP_FREE, $urandom, $urandom);
		if (pick < 96) return make_req(OP_FREE, $urandom, 32'd0);
		return make_req(OP_ALLOC, $urandom, $urandom);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: offers queued requests with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else if (in_valid && !in_stall) begin
			out_item_t r;
			r = in_data.operation == OP_FREE ? predict_free(in_data.block_address)
				: predict_alloc(in_data.request_size);
			grant_q.push_back(r);
			if (in_data.operation == OP_ALLOC && r.status == ST_OK && r.granted_address != 0)
				live_blocks.push_back(r.granted_address);
			send_gap <= $urandom_range(0, 6);
			if (request_q.size() > 0 && $urandom_range(0, 6) == 0) begin
				in_valid <= 1'b1;
				in_data <= request_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end else if (!in_valid) begin
			if (send_gap > 0) send_gap <= send_gap - 1;
			else if (request_q.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= request_q.pop_front();
			end
		end
	end

	// Monitor: random stalls, a long hold-off on request, and result checks.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
			recv_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				out_item_t e;
				if (grant_q.size() == 0) begin
					$error("result with nothing expected: %h", out_data);
					errors++;
				end else begin
					e = grant_q.pop_front();
					if (out_data.granted_address !== e.granted_address) begin
						$error("granted_address expected %h actual %h",
							e.granted_address, out_data.granted_address);
						errors++;
					end
					if (out_data.status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, out_data.status);
						errors++;
					end
				end
				recv_gap <= $urandom_range(0, 6);
				out_stall <= 1'b1;
			end else if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= stop_recv;
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if (arst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 5000) begin
				$display("Regression FAIL");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

	task automatic drain();
		while (request_q.size() > 0 || in_valid || grant_q.size() > 0) @(posedge clk);
		repeat (NUM_HOLES + 10) @(posedge clk);
	endtask

	// Base and size only matter at the first allocate; the split threshold applies from the next allocate.
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_HEAP_BASE: pred_base = val;
			CFG_HEAP_SIZE: pred_size = val;
			CFG_MIN_SPLIT: pred_split = val;
			default: ;
		endcase
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		hold_cycles = 0;
		stop_recv = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_HEAP_BASE;
		cfg_data = '0;
		reset_table();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: frees before setup, extremes, exact fit, overlap, wrap.
		request_q.push_back(make_req(OP_FREE, 32'd0, 32'd0));
		request_q.push_back(make_req(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		request_q.push_back(make_req(OP_ALLOC, 32'd0, 32'hFFFF_FFFF));
		request_q.push_back(make_req(OP_ALLOC, 32'd0, 32'd0));
		request_q.push_back(make_req(OP_FREE, 32'd0, 32'd4096));
		request_q.push_back(make_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd0));
		request_q.push_back(make_req(OP_ALLOC, 32'd100, 32'd0));
		request_q.push_back(make_req(OP_ALLOC, 32'd200, 32'd0));
		request_q.push_back(make_req(OP_ALLOC, 32'd300, 32'd0));
		request_q.push_back(make_req(OP_FREE, 32'd0, 32'd4096));
		request_q.push_back(make_req(OP_FREE, 32'd0, 32'd4196));
		request_q.push_back(make_req(OP_FREE, 32'd0, 32'd4396));
		request_q.push_back(make_req(OP_FREE, 32'd0, 32'd12345));
		request_q.push_back(make_req(OP_ALLOC, 32'd65536, 32'd0));
		request_q.push_back(make_req(OP_FREE, 32'd0, 32'd4096));
		drain();

		// The pool is already set up, so base and size are ignored from here on while
		// the split threshold of zero takes effect at the next allocate.
		write_reg(CFG_HEAP_BASE, 32'hFFFF_FF00);
		write_reg(CFG_HEAP_SIZE, 32'hFFFF_FFFF);
		write_reg(CFG_MIN_SPLIT, 32'd0);

		// Random phase with a long receiver hold-off in the middle.
		for (int n = 0; n < 1800; n++) begin
			request_q.push_back(random_req());
			if (n == 600) begin
				while (request_q.size() > 0) @(posedge clk);
				hold_cycles = 400;
			end
			if (n == 1200) drain();
			while (request_q.size() > 4) @(posedge clk);
		end
		drain();

		// Register writes at extremes: only the split threshold changes behavior now.
		write_reg(CFG_MIN_SPLIT, 32'hFFFF_FFFF);
		write_reg(CFG_HEAP_BASE, 32'd1);
		write_reg(CFG_HEAP_SIZE, 32'd1);
		for (int n = 0; n < 40; n++) request_q.push_back(random_req());
		drain();

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
